>>> hdl/wes_pkg.sv
// Package: shared types, constants and arithmetic for the wave equation step unit.
package wes_pkg;

	localparam int unsigned Points = 1024;
	localparam int unsigned IdxW = 10;
	localparam int unsigned ValW = 24;
	localparam int unsigned CW = 17;
	localparam logic [CW-1:0] CourantReset = 17'd16384;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(Points - 1);

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_START = 2'd1,
		MODE_STEP  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]             mode;
		logic [IdxW-1:0]        point_index;
		logic signed [ValW-1:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic [IdxW-1:0]        read_index;
		logic signed [ValW-1:0] displacement;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_SWEEP,
		ST_READ,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              load_wr;    // write one point into both fields
		logic              rd_issue;   // issue read of current field at index
		logic              sweep_clr;  // reset sweep counters
		logic              sweep_run;  // advance sweep one point
		logic              half;       // start step (C/2, previous field as source)
		logic              out_load;   // capture read data into output register
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_done;  // last write of the sweep retires this cycle
	} dp_sts_t;

	function automatic logic signed [ValW-1:0] sat24(input logic signed [ValW+3:0] x);
		logic signed [ValW+3:0] hi;
		logic signed [ValW+3:0] lo;
		hi = (ValW+4)'(8388607);
		lo = -(ValW+4)'(8388608);
		if (x > hi) return ValW'(hi);
		if (x < lo) return ValW'(lo);
		return x[ValW-1:0];
	endfunction

endpackage

>>> hdl/wave_equation_1d_stencil_step_unit.sv
// Top level: wave equation leapfrog step unit.
// A start or step item sweeps all 1024 points through a three-point window, one point per
// cycle from a single read port on each field bank; new items are not accepted until the
// sweep completes. Step rotates fields by swapping bank roles. Reading a point never loaded
// returns an arbitrary value.
module wave_equation_1d_stencil_step_unit import wes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [CW-1:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	logic [CW-1:0] courant_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) courant_q <= CourantReset;
		else if (cfg_we) courant_q <= cfg_wdata;
	end

	wes_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_mode(in_data.mode),
		.out_valid, .out_ready, .sts, .cmd
	);

	wes_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .in_item(in_data), .courant(courant_q),
		.out_item(out_data), .out_valid, .out_ready
	);

	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_wr && cmd.sweep_run)) else $error("load during sweep");
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> $past(cmd.rd_issue)) else $error("output without read");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_run |-> !in_ready) else $error("accept during sweep");
endmodule

>>> hdl/wes_ctrl.sv
// Controller: sequences load, read and sweep commands for the step unit.
module wes_ctrl import wes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [1:0] in_mode,
	input  logic      out_valid,
	input  logic      out_ready,
	input  dp_sts_t   sts,
	output dp_cmd_t   cmd
);
	state_t state_q, state_nxt;
	logic half_q;
	logic acc;

	assign acc = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (mode_t'(in_mode))
						MODE_LOAD: state_nxt = ST_IDLE;
						MODE_START, MODE_STEP: state_nxt = ST_PRIME;
						MODE_READ: state_nxt = ST_READ;
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_PRIME: state_nxt = ST_SWEEP;
			ST_SWEEP: if (sts.sweep_done) state_nxt = ST_IDLE;
			ST_READ: state_nxt = ST_OUT;
			ST_OUT: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE) && !(out_valid && !out_ready);
		cmd = '0;
		cmd.half = half_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_wr = acc && (mode_t'(in_mode) == MODE_LOAD);
				cmd.rd_issue = acc && (mode_t'(in_mode) == MODE_READ);
				cmd.sweep_clr = 1'b1;
			end
			ST_PRIME, ST_SWEEP: cmd.sweep_run = 1'b1;
			ST_READ: cmd.out_load = 1'b1;
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			half_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc) half_q <= (mode_t'(in_mode) == MODE_START);
		end
	end
endmodule

>>> hdl/wes_dp.sv
// Datapath: field memories, three-point window, stencil arithmetic and output register.
module wes_dp import wes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  in_item_t  in_item,
	input  logic [CW-1:0] courant,
	output out_item_t out_item,
	output logic      out_valid,
	input  logic      out_ready
);
	// Two banks; bank_q says which bank holds the current field.
	logic signed [ValW-1:0] mem_a [Points];
	logic signed [ValW-1:0] mem_b [Points];
	logic bank_q;

	// read side: address counter, data registered
	logic [IdxW:0] rd_cnt_q;
	logic [IdxW-1:0] rd_addr;
	logic signed [ValW-1:0] rd_a_q, rd_b_q;
	logic rd_v_s1;
	logic [IdxW-1:0] rd_idx_s1;

	// window
	logic signed [ValW-1:0] w0_q, w1_q, w2_q, p1_q, p2_q;
	logic [IdxW:0] win_cnt_q;
	logic win_v_q;
	// stage 2: laplacian*C
	logic signed [ValW+CW+3:0] prod_s2;
	logic signed [ValW+2:0] base_s2;
	logic [IdxW-1:0] widx_s2;
	logic v_s2;
	// stage 3: write back
	logic signed [ValW-1:0] wdat_s3;
	logic [IdxW-1:0] widx_s3;
	logic v_s3;

	logic signed [ValW-1:0] src_cur, src_prev;
	logic signed [ValW+2:0] lap;
	logic signed [ValW+3:0] rnd;
	logic signed [ValW+3:0] sum;
	logic [IdxW-1:0] ctr_idx;
	logic is_end;
	logic out_v_q;
	out_item_t out_q;
	logic rd_oob_s1;

	assign rd_addr = cmd.rd_issue ? in_item.point_index : rd_cnt_q[IdxW-1:0];

	always_ff @(posedge clk) begin
		rd_a_q <= mem_a[rd_addr];
		rd_b_q <= mem_b[rd_addr];
	end

	// start step sources the previous field and writes the current one; a step writes results to the
	// other bank, which then holds the new current field; load writes both.
	always_comb begin
		src_cur = bank_q ? rd_b_q : rd_a_q;
		src_prev = bank_q ? rd_a_q : rd_b_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && in_item.point_index <= LastIdx) begin
			mem_a[in_item.point_index] <= (in_item.point_index == '0 ||
				in_item.point_index == LastIdx) ? '0 : in_item.load_value;
			mem_b[in_item.point_index] <= (in_item.point_index == '0 ||
				in_item.point_index == LastIdx) ? '0 : in_item.load_value;
		end else if (v_s3) begin
			if (cmd.half) begin
				if (bank_q) mem_b[widx_s3] <= wdat_s3;
				else mem_a[widx_s3] <= wdat_s3;
			end else begin
				if (bank_q) mem_a[widx_s3] <= wdat_s3;
				else mem_b[widx_s3] <= wdat_s3;
			end
		end
	end

	// sweep: reads run ahead, window follows the registered read data, writes of point i lag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			rd_v_s1 <= 1'b0;
			win_cnt_q <= '0;
			win_v_q <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			bank_q <= 1'b0;
		end else begin
			if (cmd.sweep_clr) begin
				rd_cnt_q <= '0;
				rd_v_s1 <= 1'b0;
				win_cnt_q <= '0;
				win_v_q <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
			end else if (cmd.sweep_run) begin
				if (rd_cnt_q <= (IdxW+1)'(LastIdx)) rd_cnt_q <= rd_cnt_q + 1'b1;
				rd_v_s1 <= rd_cnt_q <= (IdxW+1)'(LastIdx);
				if (rd_v_s1) win_cnt_q <= win_cnt_q + 1'b1;
				// window is fresh in the cycle after a shift; only inner centers are written
				win_v_q <= rd_v_s1;
				v_s2 <= win_v_q && !is_end;
				v_s3 <= v_s2;
			end
			if (sts.sweep_done && !cmd.half) bank_q <= !bank_q;
		end
	end

	// window shift: w2 newest; center is w1 at index win_cnt-2
	always_ff @(posedge clk) begin
		if (cmd.sweep_run && rd_v_s1) begin
			w0_q <= w1_q;
			w1_q <= w2_q;
			w2_q <= cmd.half ? src_prev : src_cur;
			p1_q <= p2_q;
			p2_q <= src_prev;
		end
	end

	// center index = win_cnt-2 when the newest sample is win_cnt-1
	assign ctr_idx = win_cnt_q[IdxW-1:0] - IdxW'(2);
	assign is_end = (ctr_idx == '0) || (ctr_idx == LastIdx);
	assign lap = (ValW+3)'(w0_q) - ((ValW+3)'(w1_q) <<< 1) + (ValW+3)'(w2_q);

	// stage 2 registers the product; uses window state in the cycle after a shift
	always_ff @(posedge clk) begin
		prod_s2 <= (ValW+CW+4)'(lap) * $signed({1'b0, courant});
		base_s2 <= cmd.half ? (ValW+3)'(w1_q) :
			((ValW+3)'(w1_q) <<< 1) - (ValW+3)'(p1_q);
		widx_s2 <= ctr_idx;
	end

	always_comb begin
		logic signed [ValW+CW+3:0] r;
		if (cmd.half)
			r = (prod_s2 + (ValW+CW+4)'(65536)) >>> 17;
		else
			r = (prod_s2 + (ValW+CW+4)'(32768)) >>> 16;
		rnd = r[ValW+3:0];
		sum = (ValW+4)'(base_s2) + rnd;
	end

	always_ff @(posedge clk) begin
		wdat_s3 <= (widx_s2 == '0 || widx_s2 == LastIdx) ? '0 : sat24(sum);
		widx_s3 <= widx_s2;
	end

	assign sts.sweep_done = cmd.sweep_run && v_s3 && (widx_s3 == LastIdx - 1'b1);

	// output register; read data arrives in the cycle after issue
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_idx_s1 <= in_item.point_index;
			rd_oob_s1 <= in_item.point_index > LastIdx;
		end
		if (cmd.out_load) begin
			out_q.read_index <= rd_idx_s1;
			out_q.displacement <= rd_oob_s1 ? '0 : src_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (cmd.out_load) out_v_q <= 1'b1;
		else if (out_ready) out_v_q <= 1'b0;
	end

	assign out_valid = out_v_q;
	assign out_item = out_q;
endmodule
